FILE: hw/rtl/regex_infix_to_postfix_macros.svh
// Assertion macros shared by the checkers of this block.
`ifndef REGEX_INFIX_TO_POSTFIX_MACROS_SVH
`define REGEX_INFIX_TO_POSTFIX_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RX2PF_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RX2PF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/rx2pf_pkg.sv
package rx2pf_pkg;

	localparam int MODE_W = 3;
	localparam int SYM_W  = 16;
	localparam int OP_W   = 8;

	// token kinds on the input
	localparam logic [MODE_W-1:0] MODE_LIT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_OP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_END   = 3'd4;

	// operator characters
	localparam logic [OP_W-1:0] OPEN_MARK  = 8'h28;
	localparam logic [OP_W-1:0] CLOSE_MARK = 8'h29;
	localparam logic [OP_W-1:0] CH_STAR    = 8'h2A;
	localparam logic [OP_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [OP_W-1:0] CH_QUEST   = 8'h3F;
	localparam logic [OP_W-1:0] CH_DOT     = 8'h2E;
	localparam logic [OP_W-1:0] CH_BAR     = 8'h7C;

	typedef logic [1:0] prec_t;

	function automatic prec_t prec_of(input logic [OP_W-1:0] c);
		prec_t p;
		unique case (c)
			CH_STAR, CH_PLUS, CH_QUEST: p = 2'd3;
			CH_DOT:                     p = 2'd2;
			CH_BAR:                     p = 2'd1;
			default:                    p = 2'd0;
		endcase
		return p;
	endfunction

	// one step of the sequencer
	typedef logic [2:0] act_t;
	localparam act_t ACT_DONE    = 3'd0; // finish, no result
	localparam act_t ACT_POP     = 3'd1; // pop and emit top, keep going
	localparam act_t ACT_PUSH    = 3'd2; // push operator, finish
	localparam act_t ACT_DROP    = 3'd3; // stack full: emit dropped operator, finish
	localparam act_t ACT_DISCARD = 3'd4; // pop open group silently, finish
	localparam act_t ACT_LIT     = 3'd5; // emit literal, finish

	typedef struct packed {
		logic            push;
		logic            pop;
		logic [OP_W-1:0] wdata;
	} stk_ctl_t;

	typedef struct packed {
		logic            empty;
		logic            full;
		logic [OP_W-1:0] top;
	} stk_sts_t;

endpackage

FILE: hw/rtl/rx2pf_stack.sv
module rx2pf_stack
	import rx2pf_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  stk_ctl_t ctl,
	output stk_sts_t sts
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [OP_W-1:0] mem [DEPTH];
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_n;
	logic [CW-1:0]   rd_ptr;
	logic [OP_W-1:0] top_q;

	always_comb begin
		cnt_n = cnt_q;
		if (ctl.push) begin
			cnt_n = cnt_q + CW'(1);
		end else if (ctl.pop) begin
			cnt_n = cnt_q - CW'(1);
		end
		rd_ptr = cnt_n - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[cnt_q[AW-1:0]] <= ctl.wdata;
		end
	end

	// top_q tracks mem[count-1]; a push lands on the new top directly
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			top_q <= ctl.wdata;
		end else begin
			top_q <= mem[rd_ptr[AW-1:0]];
		end
	end

	assign sts.empty = (cnt_q == '0);
	assign sts.full  = (cnt_q == CW'(DEPTH));
	assign sts.top   = top_q;

endmodule

FILE: hw/rtl/rx2pf_pop_unit.sv
module rx2pf_pop_unit
	import rx2pf_pkg::*;
(
	input  logic [MODE_W-1:0] kind,
	input  logic [OP_W-1:0]   op,
	input  stk_sts_t          sts,
	output act_t              act
);

	logic top_open;
	logic prec_pop;

	assign top_open = (sts.top == OPEN_MARK);
	assign prec_pop = !sts.empty && !top_open && (prec_of(sts.top) >= prec_of(op));

	always_comb begin
		unique case (kind)
			MODE_LIT: begin
				act = ACT_LIT;
			end
			MODE_OP: begin
				if (prec_pop) begin
					act = ACT_POP;
				end else if (sts.full) begin
					act = ACT_DROP;
				end else begin
					act = ACT_PUSH;
				end
			end
			MODE_OPEN: begin
				act = sts.full ? ACT_DROP : ACT_PUSH;
			end
			MODE_CLOSE: begin
				if (sts.empty) begin
					act = ACT_DONE;
				end else if (top_open) begin
					act = ACT_DISCARD;
				end else begin
					act = ACT_POP;
				end
			end
			MODE_END: begin
				act = sts.empty ? ACT_DONE : ACT_POP;
			end
			default: begin
				act = ACT_DONE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/regex_infix_to_postfix.sv
// Regex infix-to-postfix converter. Takes pre-tokenized regex tokens, one per
// input beat, and emits them in postfix order using the shunting-yard rule on
// an operator stack. Literals go straight out; operators pop stacked operators
// of equal or higher precedence (* + ? over . over |), stopping at an open
// group, then get pushed; close group pops down to its open group and drops
// it; end of expression flushes everything, unmatched open groups included
// (they come out as character 40). A push onto a full stack is dropped and
// reported as an extra beat with the overflow flag set. Each input beat yields
// zero or more output beats; tlast marks the final one of that input, and an
// input that yields nothing produces no beat at all.
// Timing: s_tready is high only while the block is idle. After acceptance the
// sequencer makes one decision per cycle while not stalled, each pop reading
// the stack memory top, until the token's closing step. The last result is
// held back in the pending register so its tlast is known; it leaves on the
// token's closing step. Any cycle where the output register is full and
// m_tready is low stalls the sequencer. A finished beat may sit in the output
// register while the next token is accepted.
module regex_infix_to_postfix
	import rx2pf_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [2:0] mode, [18:3] symbol, [23:19] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] out_symbol
	output logic [1:0]  m_tuser,  // [0] is_operator, [1] overflow
	output logic        m_tlast
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WORK = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        state_n;
	logic [MODE_W-1:0] kind_q;
	logic [SYM_W-1:0]  sym_q;
	logic [OP_W-1:0]   op_q;

	// held-back result of the current token
	logic              pend_v_q;
	logic              pend_op_q;
	logic [SYM_W-1:0]  pend_sym_q;
	logic              pend_ovf_q;

	logic              out_v_q;
	logic              out_op_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_ovf_q;
	logic              out_last_q;

	logic [MODE_W-1:0] in_mode;
	logic [SYM_W-1:0]  in_sym;
	logic [MODE_W-1:0] in_kind;
	logic              accept;
	logic              can_emit;

	stk_ctl_t          stk_ctl;
	stk_sts_t          stk_sts;
	act_t              act;

	// result of this step
	logic              res_op;
	logic [SYM_W-1:0]  res_sym;
	logic              res_ovf;

	logic              emit;       // load output register
	logic              emit_pend;  // output takes pend (else res)
	logic              emit_last;
	logic              pend_load;  // pend takes res
	logic              pend_clr;

	assign in_mode  = s_tdata[2:0];
	assign in_sym   = s_tdata[18:3];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign can_emit = !out_v_q || m_tready;

	// operator codes '(' and ')' behave as group marks
	always_comb begin
		in_kind = in_mode;
		if (in_mode == MODE_OP && in_sym[OP_W-1:0] == OPEN_MARK) begin
			in_kind = MODE_OPEN;
		end else if (in_mode == MODE_OP && in_sym[OP_W-1:0] == CLOSE_MARK) begin
			in_kind = MODE_CLOSE;
		end
	end

	rx2pf_stack #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stk_ctl),
		.sts    (stk_sts)
	);

	rx2pf_pop_unit u_pop (
		.kind (kind_q),
		.op   (op_q),
		.sts  (stk_sts),
		.act  (act)
	);

	always_comb begin
		res_op  = 1'b1;
		res_sym = {{(SYM_W-OP_W){1'b0}}, stk_sts.top};
		res_ovf = 1'b0;
		if (act == ACT_DROP) begin
			res_sym = {{(SYM_W-OP_W){1'b0}}, op_q};
			res_ovf = 1'b1;
		end else if (act == ACT_LIT) begin
			res_op  = 1'b0;
			res_sym = sym_q;
		end
	end

	always_comb begin
		state_n       = state_q;
		emit          = 1'b0;
		emit_pend     = 1'b0;
		emit_last     = 1'b0;
		pend_load     = 1'b0;
		pend_clr      = 1'b0;
		stk_ctl.push  = 1'b0;
		stk_ctl.pop   = 1'b0;
		stk_ctl.wdata = op_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = S_WORK;
				end
			end
			S_WORK: begin
				if (can_emit) begin
					unique case (act)
						ACT_POP: begin
							stk_ctl.pop = 1'b1;
							emit        = pend_v_q;
							emit_pend   = 1'b1;
							pend_load   = 1'b1;
						end
						ACT_DROP, ACT_LIT: begin
							emit = 1'b1;
							if (pend_v_q) begin
								emit_pend = 1'b1;
								pend_load = 1'b1;
								state_n   = S_LAST;
							end else begin
								emit_last = 1'b1;
								state_n   = S_IDLE;
							end
						end
						default: begin
							// push, discard or nothing: token ends here
							stk_ctl.push = (act == ACT_PUSH);
							stk_ctl.pop  = (act == ACT_DISCARD);
							emit         = pend_v_q;
							emit_pend    = 1'b1;
							emit_last    = 1'b1;
							pend_clr     = 1'b1;
							state_n      = S_IDLE;
						end
					endcase
				end
			end
			S_LAST: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_pend = 1'b1;
					emit_last = 1'b1;
					pend_clr  = 1'b1;
					state_n   = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pend_load) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			sym_q  <= in_sym;
			op_q   <= (in_kind == MODE_OPEN) ? OPEN_MARK : in_sym[OP_W-1:0];
		end
		if (pend_load) begin
			pend_op_q  <= res_op;
			pend_sym_q <= res_sym;
			pend_ovf_q <= res_ovf;
		end
		if (emit) begin
			out_last_q <= emit_last;
			if (emit_pend) begin
				out_op_q  <= pend_op_q;
				out_sym_q <= pend_sym_q;
				out_ovf_q <= pend_ovf_q;
			end else begin
				out_op_q  <= res_op;
				out_sym_q <= res_sym;
				out_ovf_q <= res_ovf;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_sym_q;
	assign m_tuser  = {out_ovf_q, out_op_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: hw/rtl/rx2pf_chk.sv
`include "regex_infix_to_postfix_macros.svh"

module rx2pf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// stalled output beat holds
	`RX2PF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output beat changed under stall")

	// a literal is the only result of its token
	`RX2PF_ASSERT_NOW(a_lit_last, m_tvalid && !m_tuser[0], m_tlast, "literal beat without tlast")

	// dropped push is reported last, as an operator
	`RX2PF_ASSERT_NOW(a_ovf_last, m_tvalid && m_tuser[1], m_tlast && m_tuser[0], "overflow beat not final operator")

	// operator characters are 8 bits
	`RX2PF_ASSERT_NOW(a_op_byte, m_tvalid && m_tuser[0], m_tdata[15:8] == 8'h00, "operator beat with upper byte set")

	// the block stays busy in the cycle after an acceptance
	`RX2PF_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

bind regex_infix_to_postfix rx2pf_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: tb/testbench.sv
// Stimulus: a directed opener, then random token streams. Most streams are
// well-formed regexes built by a small recursive grammar; the rest are deep
// nests that can overrun the stack, plus raw noise in every mode. The shunting-yard
// predictor below keeps its own copy of the operator stack. Every output beat
// is checked field by field against the oldest predicted postfix token.
module testbench
	import rx2pf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STK_DEPTH   = 16;
	localparam int RAND_TOKENS = 330;
	// slack after the last expected beat: full-stack flush plus margin
	localparam int DRAIN_CYCLES = 2 * STK_DEPTH + 8;

	// mode codes the block ignores
	localparam logic [MODE_W-1:0] MODE_RSV_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSV_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSV_7 = 3'd7;

	// one input token
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SYM_W-1:0]  sym;
	} infix_tok_t;

	// one output token as the block should emit it
	typedef struct packed {
		logic             is_op;
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             ovf;
	} postfix_tok_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // [2:0] mode, [18:3] symbol, [23:19] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] out_symbol
	logic [1:0]  m_tuser;        // [0] is_operator, [1] overflow
	logic        m_tlast;

	regex_infix_to_postfix #(
		.STACK_DEPTH(STK_DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	infix_tok_t   infix_q[$];    // tokens still to be driven
	postfix_tok_t postfix_q[$];  // predicted output beats, oldest first
	postfix_tok_t step_q[$];     // scratch: beats caused by one token

	// predictor's own copy of the operator stack
	logic [OP_W-1:0] op_stk[STK_DEPTH];
	int unsigned     stk_n = 0;

	int  errors      = 0;
	int  n_accepted  = 0;
	int  n_tokens    = 0;
	bit  in_taken    = 1'b0;  // set at posedge on an input beat, cleared by driver
	bit  out_taken   = 1'b0;  // same for an output beat
	bit  calm_tx     = 1'b0;  // stretches with no idling on either side
	bit  calm_rx     = 1'b0;
	int  tx_wait     = 0;
	int  rx_wait     = 0;
	bit  tx_busy     = 1'b0;

	// ---------------------------------------------------------------- clock/reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------------------------------------------------------- predictor
	function automatic int rank_of(input logic [OP_W-1:0] c);
		unique case (c)
			CH_STAR, CH_PLUS, CH_QUEST: return 3;
			CH_DOT:                     return 2;
			CH_BAR:                     return 1;
			default:                    return 0;
		endcase
	endfunction

	function automatic void pop_to_step();
		postfix_tok_t t;
		stk_n--;
		t.is_op = 1'b1;
		t.sym   = {8'h00, op_stk[stk_n]};
		t.last  = 1'b0;
		t.ovf   = 1'b0;
		step_q.insert(step_q.size(), t);
	endfunction

	// full stack: nothing stored, the dropped char goes out flagged
	function automatic void push_or_drop(input logic [OP_W-1:0] c);
		postfix_tok_t t;
		if (stk_n < STK_DEPTH) begin
			op_stk[stk_n] = c;
			stk_n++;
		end else begin
			t.is_op = 1'b1;
			t.sym   = {8'h00, c};
			t.last  = 1'b0;
			t.ovf   = 1'b1;
			step_q.insert(step_q.size(), t);
		end
	endfunction

	function automatic void shunt_token(input logic [MODE_W-1:0] mode_in,
		input logic [SYM_W-1:0] sym_in);
		logic [MODE_W-1:0] kind;
		logic [OP_W-1:0]   ch;
		int                rk;
		postfix_tok_t      t;
		kind = mode_in;
		ch   = sym_in[OP_W-1:0];
		step_q.delete();
		// an operator spelled '(' or ')' is indistinguishable from a group mark
		if (kind == MODE_OP && ch == OPEN_MARK)
			kind = MODE_OPEN;
		else if (kind == MODE_OP && ch == CLOSE_MARK)
			kind = MODE_CLOSE;
		unique case (kind)
			MODE_LIT: begin
				t.is_op = 1'b0;
				t.sym   = sym_in;
				t.last  = 1'b0;
				t.ovf   = 1'b0;
				step_q.insert(step_q.size(), t);
			end
			MODE_OP: begin
				rk = rank_of(ch);
				while (stk_n > 0 && op_stk[stk_n-1] != OPEN_MARK &&
					rank_of(op_stk[stk_n-1]) >= rk)
					pop_to_step();
				push_or_drop(ch);
			end
			MODE_OPEN: push_or_drop(OPEN_MARK);
			MODE_CLOSE: begin
				// without a matching open this just empties the stack
				while (stk_n > 0 && op_stk[stk_n-1] != OPEN_MARK)
					pop_to_step();
				if (stk_n > 0)
					stk_n--;
			end
			MODE_END: begin
				while (stk_n > 0)
					pop_to_step();
			end
			default: ;  // unused modes do nothing
		endcase
		foreach (step_q[i]) begin
			t      = step_q[i];
			t.last = (i == step_q.size() - 1);
			postfix_q.insert(postfix_q.size(), t);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic void add_tok(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
		infix_tok_t t;
		t.mode = m;
		t.sym  = s;
		infix_q.insert(infix_q.size(), t);
	endfunction

	// operator char with junk in the upper byte now and then
	function automatic logic [SYM_W-1:0] op_sym(input logic [OP_W-1:0] c);
		logic [OP_W-1:0] hi;
		hi = ($urandom_range(0, 3) == 0) ? OP_W'($urandom) : '0;
		return {hi, c};
	endfunction

	function automatic logic [OP_W-1:0] any_op();
		unique case ($urandom_range(0, 5))
			0:       return CH_STAR;
			1:       return CH_PLUS;
			2:       return CH_QUEST;
			3:       return CH_DOT;
			4:       return CH_BAR;
			default: return OP_W'($urandom);
		endcase
	endfunction

	function automatic void add_open();
		if ($urandom_range(0, 2) == 0)
			add_tok(MODE_OP, op_sym(OPEN_MARK));
		else
			add_tok(MODE_OPEN, SYM_W'($urandom));
	endfunction

	function automatic void add_close();
		if ($urandom_range(0, 2) == 0)
			add_tok(MODE_OP, op_sym(CLOSE_MARK));
		else
			add_tok(MODE_CLOSE, SYM_W'($urandom));
	endfunction

	// well-formed grammar: alt := cat ('|' cat)*, cat := atom ('.' atom)*,
	// atom := literal | '(' alt ')', each atom optionally followed by * + ?
	task automatic gen_atom(input int lvl);
		int k;
		if (lvl < 3 && $urandom_range(0, 3) == 0) begin
			add_open();
			gen_alt(lvl + 1);
			add_close();
		end else begin
			add_tok(MODE_LIT, SYM_W'($urandom));
		end
		if ($urandom_range(0, 2) == 0) begin
			k = $urandom_range(0, 2);
			add_tok(MODE_OP, op_sym(k == 0 ? CH_STAR : (k == 1 ? CH_PLUS : CH_QUEST)));
		end
	endtask

	task automatic gen_cat(input int lvl);
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				add_tok(MODE_OP, op_sym(CH_DOT));
			gen_atom(lvl);
		end
	endtask

	task automatic gen_alt(input int lvl);
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				add_tok(MODE_OP, op_sym(CH_BAR));
			gen_cat(lvl);
		end
	endtask

	// nest of opens mixed with literals and operators, can be deep enough to overrun the stack
	task automatic gen_deep(input int levels, input bit dense);
		for (int i = 0; i < levels; i++) begin
			add_open();
			if (dense || $urandom_range(0, 1) == 0)
				add_tok(MODE_LIT, SYM_W'($urandom));
			if (dense || $urandom_range(0, 1) == 0)
				add_tok(MODE_OP, op_sym(any_op()));
		end
		repeat ($urandom_range(0, levels))
			add_close();
		add_tok(MODE_END, SYM_W'($urandom));
	endtask

	task automatic gen_noise();
		logic [MODE_W-1:0] m;
		repeat ($urandom_range(1, 8)) begin
			m = MODE_W'($urandom);
			if (m == MODE_OP && $urandom_range(0, 1) == 0)
				add_tok(m, op_sym(any_op()));
			else
				add_tok(m, SYM_W'($urandom));
		end
		if ($urandom_range(0, 1) == 0)
			add_tok(MODE_END, SYM_W'($urandom));
	endtask

	task automatic build_tokens();
		int goal;
		int pick;
		// directed opener
		add_tok(MODE_END, 16'h0000);        // flush of an empty stack
		add_tok(MODE_CLOSE, 16'hFFFF);      // close of an empty stack
		add_tok(MODE_RSV_5, 16'hFFFF);      // unused modes: no beats
		add_tok(MODE_RSV_6, 16'h0000);
		add_tok(MODE_RSV_7, 16'hA5A5);
		add_tok(MODE_LIT, 16'h0000);
		add_tok(MODE_OP, {8'h00, CH_BAR});
		add_tok(MODE_LIT, 16'hFFFF);
		add_tok(MODE_OP, {8'hFF, CH_DOT});  // pops nothing: '|' ranks lower
		add_tok(MODE_OP, {8'h01, OPEN_MARK}); // operator char '(' opens a group
		add_tok(MODE_LIT, 16'h1234);
		add_tok(MODE_OP, {8'h00, CH_STAR});
		add_tok(MODE_OP, {8'h00, CH_PLUS}); // equal rank pops '*'
		add_tok(MODE_OP, {8'h80, CH_QUEST});
		add_tok(MODE_OP, {8'hFF, CLOSE_MARK}); // operator char ')' closes it
		add_tok(MODE_OP, {8'h00, 8'h41});   // rank-0 char pops everything
		add_tok(MODE_OP, {8'hFF, 8'hFF});
		add_tok(MODE_CLOSE, 16'h0000);      // close with no open pops all
		add_tok(MODE_OPEN, 16'h5A5A);
		add_tok(MODE_OPEN, 16'h0000);
		add_tok(MODE_END, 16'hFFFF);        // unmatched opens come out as '('
		// random part, opening with a guaranteed stack overrun
		goal = infix_q.size() + RAND_TOKENS;
		gen_deep(STK_DEPTH + 2, 1'b1);
		while (infix_q.size() < goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				gen_alt(0);
				add_tok(MODE_END, SYM_W'($urandom));
			end else if (pick == 7) begin
				gen_deep($urandom_range(6, STK_DEPTH + 2), 1'b0);
			end else begin
				gen_noise();
			end
		end
	endtask

	// ---------------------------------------------------------------- driver
	// Inputs change on the falling edge. A beat taken at the previous rising
	// edge retires the head token, then a fresh gap is drawn before the next.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				infix_q.delete(0);
				tx_busy = 1'b0;
				if ($urandom_range(0, 39) == 0)
					calm_tx = !calm_tx;
				tx_wait = calm_tx ? 0 : $urandom_range(0, 6);
			end
			if (!tx_busy) begin
				if (tx_wait > 0)
					tx_wait--;
				else if (infix_q.size() > 0)
					tx_busy = 1'b1;
			end
			s_tvalid <= tx_busy;
			if (tx_busy)
				s_tdata <= {5'b0, infix_q[0].sym, infix_q[0].mode};
		end
	end

	// receiver: after each taken beat, hold tready low for a random stall
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 1'b0;
				if ($urandom_range(0, 39) == 0)
					calm_rx = !calm_rx;
				rx_wait = calm_rx ? 0 : $urandom_range(0, 6);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		postfix_tok_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				out_taken = 1'b1;
				if (postfix_q.size() == 0) begin
					$error("output beat with nothing pending: out_symbol %0h", m_tdata);
					errors++;
				end else begin
					want = postfix_q.pop_front();
					check_field("is_operator", 16'(want.is_op), 16'(m_tuser[0]));
					check_field("out_symbol", want.sym, m_tdata);
					check_field("last", 16'(want.last), 16'(m_tlast));
					check_field("overflow", 16'(want.ovf), 16'(m_tuser[1]));
				end
			end
			if (s_tvalid && s_tready) begin
				in_taken = 1'b1;
				n_accepted++;
				shunt_token(s_tdata[2:0], s_tdata[18:3]);
			end
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		build_tokens();
		n_tokens = infix_q.size();
		wait (arst_n);
		wait (n_accepted == n_tokens);
		wait (postfix_q.size() == 0);
		// any stray beat in this window is caught by the monitor
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("regex_infix_to_postfix verification clean");
		else
			$display("regex_infix_to_postfix verification failed");
		$finish;
	end

	// hard stop: worst case is far below this
	initial begin
		#5_000_000;
		$display("regex_infix_to_postfix verification failed");
		$finish;
	end

endmodule
